/* rtl/mvpm_pkg.sv */
// Package with the shared types and constants of the multi-voice PCM mixer.
`default_nettype none
package mvpm_pkg;
  typedef enum logic [2:0] {
    FUNC_WRITE = 3'd0,
    FUNC_START = 3'd1,
    FUNC_VOLUME = 3'd2,
    FUNC_STOP = 3'd3,
    FUNC_TICK = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VREAD,
    ST_SREAD0,
    ST_SREAD1,
    ST_SCALE,
    ST_ACCUM,
    ST_OUT
  } state_t;

  localparam int GAIN_FULL = 100;
  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;
endpackage
`default_nettype wire

/* rtl/mvpm_sample_mem.sv */
// Sample memory: one write port and one registered read port.
`default_nettype none
module mvpm_sample_mem
  import mvpm_pkg::*;
#(
  parameter int SAMPLE_WORDS = 65536,
  localparam int AW = $clog2(SAMPLE_WORDS)
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic signed [15:0]   wr_data,
  input  wire logic [AW-1:0]        rd_addr,
  output logic signed [15:0]        rd_data
);
  logic signed [15:0] mem [SAMPLE_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

/* rtl/mvpm_voice_mem.sv */
// Voice table memory with a registered read port and a write port.
`default_nettype none
module mvpm_voice_mem
  import mvpm_pkg::*;
#(
  parameter int VOICE_COUNT = 9,
  parameter int WIDTH = 90,
  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [VW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [VW-1:0]    rd_addr,
  output logic [WIDTH-1:0]      rd_data
);
  logic [WIDTH-1:0] mem [VOICE_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

/* rtl/multi_voice_pcm_mixer.sv */
// Top level of the multi-voice PCM mixer: control sequencer and datapath.
// The block takes one command transaction on the in_ channel and answers each
// with exactly one result transaction on the out_ channel. Commands write a
// sample word, start, set the volume of or stop a voice, or tick the mixer.
// A non-tick command goes from idle through the voice-read state to the final
// state, where its result is registered; the next command is taken in idle.
// A tick visits every voice in turn: a voice table read, then for an active
// voice one or two sample memory reads, a scale step and an accumulate step.
// The single read port of the sample memory and the walk over the voice table
// set how long a tick lasts. The block holds one item at a time: in_tready is
// high only while idle. The result sits in an output register until the
// receiver takes it; a command accepted meanwhile is processed, but its
// result waits in the final state, so a stall on out_tready soon holds off
// the input.
// Reset clears the active flags of all voices and sets every gain to 100.
// The sample memory is not cleared: a word never written reads as an
// arbitrary value. Sample memory and voice addresses wrap modulo SAMPLE_WORDS.
`default_nettype none
module multi_voice_pcm_mixer
  import mvpm_pkg::*;
#(
  parameter int VOICE_COUNT = 9,
  parameter int SAMPLE_WORDS = 65536,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: func[2:0], voice[6:3], address[22:7], sample_value[38:23],
  // frame_count[54:39], stereo[55], rate_step[73:56], gain[80:74]
  input  wire logic [87:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: mix_level[15:0], sample_valid[16], voices_seen[17], busy_mask[26:18]
  output logic [31:0]      out_tdata
);
  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  // Voice entry: base 16, length 16, stereo 1, position 32, step 18.
  localparam int ENT_W = 83;

  // Input fields.
  logic [2:0]  f_func;
  logic [3:0]  f_voice;
  logic [15:0] f_addr;
  logic [15:0] f_sample;
  logic [15:0] f_frames;
  logic        f_stereo;
  logic [17:0] f_step;
  logic [6:0]  f_gain;
  assign f_func   = in_tdata[2:0];
  assign f_voice  = in_tdata[6:3];
  assign f_addr   = in_tdata[22:7];
  assign f_sample = in_tdata[38:23];
  assign f_frames = in_tdata[54:39];
  assign f_stereo = in_tdata[55];
  assign f_step   = in_tdata[73:56];
  assign f_gain   = in_tdata[80:74];

  state_t state_r, state_nxt;

  // Latched command.
  logic [2:0]  cmd_func_r;
  logic [3:0]  cmd_voice_r;
  logic [15:0] cmd_addr_r;
  logic [15:0] cmd_sample_r;
  logic [15:0] cmd_frames_r;
  logic        cmd_stereo_r;
  logic [17:0] cmd_step_r;
  logic [6:0]  cmd_gain_r;

  // Per-voice flags and gain in flops (small; reset clears the flags and sets the gains to full).
  logic [VOICE_COUNT-1:0] active_r;
  logic [6:0]             gain_r [VOICE_COUNT];

  logic [VW-1:0]          vidx_r;
  logic signed [19:0]     mix_r;
  logic                   any_r;
  logic signed [15:0]     s0_r;
  logic signed [16:0]     smp_r;
  logic signed [23:0]     prod_r;
  logic [ENT_W-1:0]       ent_r;

  logic [31:0] out_tdata_r;
  logic        out_tvalid_r;

  // Voice table memory.
  logic             vm_we;
  logic [VW-1:0]    vm_waddr;
  logic [ENT_W-1:0] vm_wdata;
  logic [VW-1:0]    vm_raddr;
  logic [ENT_W-1:0] vm_rdata;

  mvpm_voice_mem #(.VOICE_COUNT(VOICE_COUNT), .WIDTH(ENT_W)) u_voice_mem (
    .clk(clk), .wr_en(vm_we), .wr_addr(vm_waddr), .wr_data(vm_wdata),
    .rd_addr(vm_raddr), .rd_data(vm_rdata)
  );

  // Sample memory.
  logic              sm_we;
  logic [AW-1:0]     sm_raddr;
  logic signed [15:0] sm_rdata;

  mvpm_sample_mem #(.SAMPLE_WORDS(SAMPLE_WORDS)) u_sample_mem (
    .clk(clk), .wr_en(sm_we), .wr_addr(AW'(cmd_addr_r)),
    .wr_data(cmd_sample_r), .rd_addr(sm_raddr), .rd_data(sm_rdata)
  );

  // Fields of the voice entry being processed.
  logic [15:0] e_base;
  logic [15:0] e_len;
  logic        e_stereo;
  logic [31:0] e_pos;
  logic [17:0] e_step;
  assign e_base   = ent_r[15:0];
  assign e_len    = ent_r[31:16];
  assign e_stereo = ent_r[32];
  assign e_pos    = ent_r[64:33];
  assign e_step   = ent_r[82:65];

  logic [31:0] r_pos;
  logic [15:0] r_base;
  logic [15:0] r_len;
  logic        r_stereo;
  assign r_base   = vm_rdata[15:0];
  assign r_len    = vm_rdata[31:16];
  assign r_stereo = vm_rdata[32];
  assign r_pos    = vm_rdata[64:33];

  logic [31:0] r_idx;
  logic [32:0] r_ofs;
  logic        r_end;
  assign r_idx = r_pos >> FRACTION_BITS;
  assign r_end = (r_idx >= {16'd0, r_len});
  assign r_ofs = r_stereo ? {r_idx, 1'b0} : {1'b0, r_idx};

  logic [32:0] sum_addr;
  assign sum_addr = {17'd0, r_base} + r_ofs;

  logic [32:0] np;
  assign np = {1'b0, e_pos} + {15'd0, e_step};

  logic cmd_vok;
  assign cmd_vok = ({28'd0, cmd_voice_r} < VOICE_COUNT);
  logic [VW-1:0] cmd_vsel;
  assign cmd_vsel = cmd_voice_r[VW-1:0];

  logic last_voice;
  assign last_voice = ({{(32-VW){1'b0}}, vidx_r} == VOICE_COUNT - 1);

  logic [AW-1:0] rd_addr_r;
  logic          is_tick;
  assign is_tick = (cmd_func_r == FUNC_TICK);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_VREAD;
      end
      ST_VREAD: begin
        if (!is_tick || !active_r[vidx_r] || r_end) begin
          state_nxt = (!is_tick || last_voice) ? ST_OUT : ST_VREAD;
        end else begin
          state_nxt = ST_SREAD0;
        end
      end
      ST_SREAD0: state_nxt = e_stereo ? ST_SREAD1 : ST_SCALE;
      ST_SREAD1: state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_ACCUM;
      ST_ACCUM:  state_nxt = last_voice ? ST_OUT : ST_VREAD;
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    vm_we    = 1'b0;
    vm_waddr = vidx_r;
    vm_wdata = ent_r;
    vm_raddr = vidx_r;
    sm_we    = 1'b0;
    sm_raddr = rd_addr_r;
    in_tready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: vm_raddr = '0;
      ST_VREAD: begin
        vm_raddr = vidx_r + VW'(1);
        sm_raddr = sum_addr[AW-1:0];
        if (!is_tick) begin
          sm_we = (cmd_func_r == FUNC_WRITE);
          if (cmd_func_r == FUNC_START && cmd_vok) begin
            vm_we    = 1'b1;
            vm_waddr = cmd_vsel;
            vm_wdata = {cmd_step_r, 32'd0, cmd_stereo_r, cmd_frames_r, cmd_addr_r};
          end
        end
      end
      ST_SREAD0: sm_raddr = rd_addr_r + AW'(1);
      ST_ACCUM: begin
        vm_we    = 1'b1;
        vm_wdata = {e_step, np[32] ? 32'hFFFF_FFFF : np[31:0], ent_r[32:0]};
        vm_raddr = vidx_r + VW'(1);
      end
      default: ;
    endcase
  end

  logic signed [19:0] mix_sat_in;
  logic signed [15:0] mix_sat;
  assign mix_sat_in = mix_r;
  always_comb begin
    if (mix_sat_in > 20'sd32767) mix_sat = 16'sh7FFF;
    else if (mix_sat_in < -20'sd32768) mix_sat = 16'sh8000;
    else mix_sat = mix_sat_in[15:0];
  end

  logic [15:0] busy16;
  always_comb begin
    busy16 = '0;
    for (int v = 0; v < VOICE_COUNT; v++) busy16[v] = active_r[v];
  end

  // Scaled sample: truncating divide by 100 via reciprocal (|p| < 2^22).
  logic [22:0] mag;
  logic [49:0] q_full;
  logic [15:0] q;
  logic signed [16:0] scaled;
  assign mag    = prod_r[23] ? 23'(-prod_r) : prod_r[22:0];
  assign q_full = {27'd0, mag} * 50'd85899346;  // ceil(2^33/100)
  assign q      = q_full[48:33];
  assign scaled = prod_r[23] ? -$signed({1'b0, q}) : $signed({1'b0, q});

  logic signed [16:0] pair_sum;
  assign pair_sum = $signed({s0_r[15], s0_r}) + $signed({sm_rdata[15], sm_rdata});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      active_r     <= '0;
      out_tvalid_r <= 1'b0;
      for (int v = 0; v < VOICE_COUNT; v++) gain_r[v] <= 7'(GAIN_FULL);
    end else begin
      state_r <= state_nxt;
      // The result register frees itself on any accepting edge and is refilled
      // only from the final state.
      if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_func_r   <= f_func;
            cmd_voice_r  <= f_voice;
            cmd_addr_r   <= f_addr;
            cmd_sample_r <= f_sample;
            cmd_frames_r <= f_frames;
            cmd_stereo_r <= f_stereo;
            cmd_step_r   <= f_step;
            cmd_gain_r   <= f_gain;
            vidx_r <= '0;
            mix_r  <= '0;
            any_r  <= 1'b0;
          end
        end
        ST_VREAD: begin
          ent_r     <= vm_rdata;
          rd_addr_r <= sum_addr[AW-1:0];
          if (!is_tick) begin
            if (cmd_vok) begin
              if (cmd_func_r == FUNC_START) active_r[cmd_vsel] <= 1'b1;
              if (cmd_func_r == FUNC_STOP) active_r[cmd_vsel] <= 1'b0;
              if (cmd_func_r == FUNC_VOLUME)
                gain_r[cmd_vsel] <= (cmd_gain_r > 7'(GAIN_FULL)) ? 7'(GAIN_FULL)
                                                                 : cmd_gain_r;
            end
          end else begin
            if (active_r[vidx_r]) begin
              any_r <= 1'b1;
              if (r_end) active_r[vidx_r] <= 1'b0;
            end
            if (!active_r[vidx_r] || r_end) vidx_r <= vidx_r + VW'(1);
          end
        end
        ST_SREAD0: s0_r <= sm_rdata;
        ST_SREAD1: begin
          smp_r <= pair_sum / 17'sd2;
        end
        ST_SCALE: begin
          if (!e_stereo) smp_r <= {s0_r[15], s0_r};
          prod_r <= (e_stereo ? smp_r : $signed({s0_r[15], s0_r}))
                    * $signed({1'b0, gain_r[vidx_r]});
        end
        ST_ACCUM: begin
          mix_r  <= mix_r + 20'(scaled);
          vidx_r <= vidx_r + VW'(1);
        end
        ST_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {5'd0, busy16[8:0], any_r, is_tick,
                             is_tick ? mix_sat : 16'd0};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the multi-voice PCM mixer, with a scoreboard and random idling.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import mvpm_pkg::*;

  localparam int VOICES = 9;
  localparam int RANDOM_ITEMS = 1850;

  // One command transaction as it travels on in_tdata.
  typedef struct packed {
    logic [6:0]  gain;
    logic [17:0] rate_step;
    logic        stereo;
    logic [15:0] frame_count;
    logic [15:0] sample_value;
    logic [15:0] address;
    logic [3:0]  voice;
    logic [2:0]  func;
  } command_t;

  // One result transaction as it is expected on out_tdata.
  typedef struct packed {
    logic [8:0]  busy_mask;
    logic        voices_seen;
    logic        sample_valid;
    logic [15:0] mix_level;
  } mix_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  always #4 clk = ~clk;

  multi_voice_pcm_mixer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Shadow copy of the mixer state. Written words are tracked so that the
  // stimulus never points a voice at memory whose content is undefined.
  logic signed [15:0] mem_shadow [int];
  logic        act_sh [VOICES];
  logic [15:0] base_sh [VOICES];
  logic [15:0] len_sh [VOICES];
  logic        stereo_sh [VOICES];
  logic [31:0] pos_sh [VOICES];
  logic [17:0] step_sh [VOICES];
  logic [6:0]  gain_sh [VOICES];

  command_t    pending_cmds[$];
  mix_result_t expected_mix[$];
  int          failures = 0;
  bit          no_idle = 1'b0;
  bit          hold_sender = 1'b0;

  // The predictor: applies one command to the shadow state and queues the
  // result the block must give for it.
  function automatic void predict_mix(command_t c);
    mix_result_t r;
    int          acc;
    int          smp;
    logic [31:0] idx;
    logic [16:0] a;
    logic [32:0] np;
    int          v;
    r = '0;
    acc = 0;
    v = c.voice;
    case (c.func)
      FUNC_WRITE: mem_shadow[c.address] = c.sample_value;
      FUNC_START: if (v < VOICES) begin
        base_sh[v] = c.address;
        len_sh[v] = c.frame_count;
        stereo_sh[v] = c.stereo;
        step_sh[v] = c.rate_step;
        pos_sh[v] = '0;
        act_sh[v] = 1'b1;
      end
      FUNC_VOLUME: if (v < VOICES) gain_sh[v] = (c.gain > GAIN_FULL) ? 7'd100 : c.gain;
      FUNC_STOP: if (v < VOICES) act_sh[v] = 1'b0;
      FUNC_TICK: begin
        r.sample_valid = 1'b1;
        for (int k = 0; k < VOICES; k++) begin
          if (act_sh[k]) begin
            r.voices_seen = 1'b1;
            idx = pos_sh[k] >> 16;
            if (idx >= len_sh[k]) begin
              act_sh[k] = 1'b0;
            end else begin
              if (stereo_sh[k]) begin
                a = base_sh[k] + 2 * idx[15:0];
                smp = (int'(mem_shadow[a[15:0]]) + int'(mem_shadow[16'(a[15:0] + 1)])) / 2;
              end else begin
                smp = mem_shadow[16'(base_sh[k] + idx[15:0])];
              end
              acc += (smp * int'(gain_sh[k])) / 100;
              np = {1'b0, pos_sh[k]} + step_sh[k];
              pos_sh[k] = np[32] ? 32'hFFFF_FFFF : np[31:0];
            end
          end
        end
        if (acc > SAT_MAX) acc = SAT_MAX;
        else if (acc < SAT_MIN) acc = SAT_MIN;
        r.mix_level = acc[15:0];
      end
      default: ;
    endcase
    for (int k = 0; k < VOICES; k++) r.busy_mask[k] = act_sh[k];
    expected_mix.push_back(r);
  endfunction

  function automatic command_t make_cmd(logic [2:0] f, int v, int addr, int frames, bit st,
                                        int step, int g, int val);
    command_t c;
    c.func = f;
    c.voice = v[3:0];
    c.address = addr[15:0];
    c.sample_value = val[15:0];
    c.frame_count = frames[15:0];
    c.stereo = st;
    c.rate_step = step[17:0];
    c.gain = g[6:0];
    return c;
  endfunction

  // Random content for the unused fields so that every bit toggles.
  function automatic command_t noisy(logic [2:0] f, int v);
    return make_cmd(f, v, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Writes a block of sample words, then starts a voice over it, so that
  // every frame the voice can reach has been written.
  task automatic queue_voice(int v, int frames, bit st, int step, bit extreme);
    int base;
    int words;
    base = $urandom;
    words = st ? 2 * frames : frames;
    for (int i = 0; i < words; i++) begin
      pending_cmds.push_back(make_cmd(FUNC_WRITE, $urandom, base + i, $urandom, $urandom,
        $urandom, $urandom, extreme ? ($urandom_range(0, 1) ? 32767 : -32768) : $urandom));
    end
    pending_cmds.push_back(make_cmd(FUNC_START, v, base, frames, st, step, $urandom,
                                    $urandom));
  endtask

  // Driver: holds the head of the queue on in_tdata until it is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_mix(command_t'(in_tdata[80:0]));
        void'(pending_cmds.pop_front());
      end
      if (hold_sender || pending_cmds.size() == 0 ||
          (!no_idle && ($urandom_range(0, 99) < 32) &&
           !(in_tvalid && !in_tready))) begin
        in_tvalid <= (in_tvalid && !in_tready) ? 1'b1 : 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= {7'd0, pending_cmds[0]};
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    mix_result_t got;
    mix_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[26:0];
        if (expected_mix.size() == 0) begin
          $error("result with no expectation: %h", got);
          failures++;
        end else begin
          want = expected_mix.pop_front();
          if (got.mix_level !== want.mix_level) begin
            $error("mix_level expected %0d actual %0d", $signed(want.mix_level),
                   $signed(got.mix_level));
            failures++;
          end
          if (got.sample_valid !== want.sample_valid) begin
            $error("sample_valid expected %0b actual %0b", want.sample_valid,
                   got.sample_valid);
            failures++;
          end
          if (got.voices_seen !== want.voices_seen) begin
            $error("voices_seen expected %0b actual %0b", want.voices_seen,
                   got.voices_seen);
            failures++;
          end
          if (got.busy_mask !== want.busy_mask) begin
            $error("busy_mask expected %h actual %h", want.busy_mask, got.busy_mask);
            failures++;
          end
        end
      end
      out_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 32);
    end
  end

  initial begin
    for (int k = 0; k < VOICES; k++) begin
      act_sh[k] = 0; base_sh[k] = 0; len_sh[k] = 0; stereo_sh[k] = 0;
      pos_sh[k] = 0; step_sh[k] = 0; gain_sh[k] = 7'd100;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: every operation, field extremes, out-of-range voices,
    // gain saturation, zero length, a tick with nothing active and saturation
    // of the sum with all nine voices at full scale.
    pending_cmds.push_back(noisy(FUNC_TICK, 0));
    pending_cmds.push_back(noisy(3'd5, 0));
    pending_cmds.push_back(noisy(3'd7, 15));
    pending_cmds.push_back(make_cmd(FUNC_START, 9, 0, 4, 0, 65536, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_VOLUME, 15, 0, 0, 0, 0, 50, 0));
    pending_cmds.push_back(make_cmd(FUNC_STOP, 12, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_START, 0, 0, 0, 1, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_WRITE, 0, 65535, 0, 0, 0, 0, 32767));
    pending_cmds.push_back(make_cmd(FUNC_WRITE, 0, 0, 0, 0, 0, 0, -32768));
    // Stereo voice straddling the top of memory wraps back to address zero.
    pending_cmds.push_back(make_cmd(FUNC_START, 8, 65535, 1, 1, 262143, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_VOLUME, 8, 0, 0, 0, 0, 127, 0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0));
    for (int v = 0; v < VOICES; v++) begin
      pending_cmds.push_back(make_cmd(FUNC_START, v, 65535, 65535, 0, 0, 0, 0));
    end
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0));
    for (int v = 0; v < VOICES; v++) begin
      pending_cmds.push_back(make_cmd(FUNC_START, v, 0, 65535, 0, 0, 0, 0));
    end
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0));
    for (int v = 0; v < VOICES; v++) begin
      pending_cmds.push_back(make_cmd(FUNC_VOLUME, v, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(FUNC_STOP, v, 0, 0, 0, 0, 0, 0));
    end
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0));
    wait (pending_cmds.size() == 0);

    // Let the sender sit until every result is back, then run with no idling.
    hold_sender = 1'b1;
    wait (expected_mix.size() == 0);
    hold_sender = 1'b0;
    no_idle = 1'b1;
    queue_voice(1, 2, 1, 65536, 1'b1);
    queue_voice(2, 3, 0, 32768, 1'b1);
    for (int i = 0; i < 8; i++) pending_cmds.push_back(noisy(FUNC_TICK, 0));
    wait (pending_cmds.size() == 0);
    no_idle = 1'b0;

    // Random part: mostly well-formed voice setups followed by ticks, with
    // some noise and stray commands mixed in.
    while (pending_cmds.size() < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: queue_voice($urandom_range(0, VOICES - 1), $urandom_range(0, 6),
                          $urandom_range(0, 1),
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 262143)
                                                    : $urandom_range(0, 131072),
                          $urandom_range(0, 3) == 0);
        2: pending_cmds.push_back(make_cmd(FUNC_VOLUME, $urandom_range(0, 15), $urandom,
                                           $urandom, $urandom, $urandom,
                                           $urandom_range(0, 127), $urandom));
        3: pending_cmds.push_back(noisy(FUNC_STOP, $urandom_range(0, 15)));
        4: pending_cmds.push_back(noisy(3'($urandom_range(5, 7)), $urandom));
        5: pending_cmds.push_back(make_cmd(FUNC_START, $urandom_range(9, 15), $urandom,
                                           $urandom, $urandom, $urandom, $urandom, $urandom));
        default: pending_cmds.push_back(noisy(FUNC_TICK, $urandom));
      endcase
    end
    wait (pending_cmds.size() == 0);
    wait (expected_mix.size() == 0);
    repeat (100) @(posedge clk);
    if (failures == 0 && expected_mix.size() == 0) begin
      $display("multi_voice_pcm_mixer test passed");
    end else begin
      $display("multi_voice_pcm_mixer test failed");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run of a few thousand commands.
  initial begin
    #20ms;
    $display("multi_voice_pcm_mixer test failed");
    $finish;
  end
endmodule
`default_nettype wire
